FILE: design/ustc_pkg.sv
// Types and constants shared by the Unix-seconds-to-calendar block.
// No dependencies; every other design file imports this package.
package ustc_pkg;

    localparam int TS_W     = 31;
    localparam int YEAR_W   = 11;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOURS_W  = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int SOD_W    = 17;
    localparam int DAYS_W   = 15;
    localparam int TOD_W    = 12;
    localparam int PROD_W   = 49;
    localparam int YLEN_W   = 9;

    localparam logic [SOD_W-1:0]  SECS_PER_DAY  = 17'd86400;
    localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 12'd3600;
    localparam logic [MIN_W-1:0]  SECS_PER_MIN  = 6'd60;
    // A day is 675 * 2**7 seconds: the timestamp drops its low 7 bits and is then
    // multiplied by the reciprocal of 675 scaled by 2**34.
    localparam int                DAY_PRE_SHIFT = 7;
    localparam logic [24:0]       DAY_RECIP     = 25'd25451659;
    localparam int                DAY_SHIFT     = 34;
    // Reciprocals scaled by 2**32 and 2**18, rounded up; exact over the ranges used.
    localparam logic [20:0]       HOUR_RECIP    = 21'd1193047;
    localparam int                HOUR_SHIFT    = 32;
    localparam logic [12:0]       MIN_RECIP     = 13'd4370;
    localparam int                MIN_SHIFT     = 18;
    localparam logic [YEAR_W-1:0] EPOCH_YEAR    = 11'd1970;
    localparam logic [1:0]        EPOCH_MOD4    = 2'd2;
    localparam logic [6:0]        EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]        EPOCH_MOD400  = 9'd370;
    localparam logic [YLEN_W-1:0] DAYS_COMMON   = 9'd365;
    localparam logic [YLEN_W-1:0] DAYS_LEAP     = 9'd366;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd0;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd5;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd8;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd10;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd11;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY_M,
        S_DAY_R,
        S_TOD_H,
        S_TOD_HS,
        S_TOD_M,
        S_TOD_MS,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TS_W-1:0] unix_seconds;
    } t_in_word;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [HOURS_W-1:0] hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic day_mul;
        logic day_rem;
        logic tod_h;
        logic tod_hs;
        logic tod_m;
        logic tod_ms;
        logic year_step;
        logic month_step;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_busy;
    } t_ctl_status;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] idx,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (idx)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: design/ustc_if.sv
// Valid/ready stream interfaces for the input and result words.
// Depends on ustc_pkg for the payload types.
interface ustc_in_if;
    import ustc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ustc_out_if;
    import ustc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/ustc_ctrl.sv
// Controller state machine: sequences the day split, time of day, year and month walks.
// Depends on ustc_pkg; drives the datapath through t_ctl_cmd.
module ustc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ustc_pkg::t_ctl_status i_status,
    output ustc_pkg::t_ctl_cmd   o_cmd
);
    import ustc_pkg::*;

    t_state             r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DAY_M;
            end
            S_DAY_M:  n_state = S_DAY_R;
            S_DAY_R:  n_state = S_TOD_H;
            S_TOD_H:  n_state = S_TOD_HS;
            S_TOD_HS: n_state = S_TOD_M;
            S_TOD_M:  n_state = S_TOD_MS;
            S_TOD_MS: n_state = S_YEAR;
            S_YEAR: begin
                if (i_status.year_done) n_state = S_MONTH;
            end
            S_MONTH: begin
                if (i_status.month_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DAY_M:  o_cmd.day_mul  = 1'b1;
            S_DAY_R:  o_cmd.day_rem  = 1'b1;
            S_TOD_H:  o_cmd.tod_h    = 1'b1;
            S_TOD_HS: o_cmd.tod_hs   = 1'b1;
            S_TOD_M:  o_cmd.tod_m    = 1'b1;
            S_TOD_MS: o_cmd.tod_ms   = 1'b1;
            S_YEAR:   o_cmd.year_step  = !i_status.year_done;
            S_MONTH:  o_cmd.month_step = !i_status.month_done;
            S_DONE:   o_cmd.out_load   = !i_status.out_busy;
            default: ;
        endcase
    end

endmodule

FILE: design/ustc_dp.sv
// Datapath: reciprocal day split and time-of-day split,
// year and month counters, and the output word register. Depends on ustc_pkg.
module ustc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ustc_pkg::t_ctl_cmd    i_cmd,
    output ustc_pkg::t_ctl_status o_status,
    input  logic [ustc_pkg::TS_W-1:0] i_unix_seconds,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ustc_pkg::t_out_word   o_out_word
);
    import ustc_pkg::*;

    logic [TS_W-1:0]    r_ts;
    logic [SOD_W-1:0]   r_rem;
    logic [PROD_W-1:0]  r_prod;
    logic [TOD_W-1:0]   r_tod_rem;
    logic [HOURS_W-1:0] r_hours;
    logic [MIN_W-1:0]   r_minutes;
    logic [SEC_W-1:0]   r_seconds;
    logic [DAYS_W-1:0]  r_days;
    logic [YEAR_W-1:0]  r_year;
    logic [1:0]         r_mod4;
    logic [6:0]         r_mod100;
    logic [8:0]         r_mod400;
    logic [MONTH_W-1:0] r_midx;
    t_out_word          r_out;
    logic               r_out_valid;

    logic               leap;
    logic [YLEN_W-1:0]  ylen;
    logic [DAY_W-1:0]   mlen;
    logic [DAYS_W-1:0]  days_q;
    logic [HOURS_W-1:0] hours_q;
    logic [MIN_W-1:0]   min_q;

    assign leap    = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
    assign ylen    = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mlen    = month_len(r_midx, leap);
    assign days_q  = r_prod[DAY_SHIFT +: DAYS_W];
    assign hours_q = r_prod[HOUR_SHIFT +: HOURS_W];
    assign min_q   = r_prod[MIN_SHIFT +: MIN_W];

    assign o_status.year_done  = r_days < DAYS_W'(ylen);
    assign o_status.month_done = (r_days < DAYS_W'(mlen)) || (r_midx == MON_DEC);
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ts     <= i_unix_seconds;
            r_year   <= EPOCH_YEAR;
            r_mod4   <= EPOCH_MOD4;
            r_mod100 <= EPOCH_MOD100;
            r_mod400 <= EPOCH_MOD400;
            r_midx   <= MON_JAN;
        end
        if (i_cmd.day_mul) begin
            r_prod <= PROD_W'(r_ts[TS_W-1:DAY_PRE_SHIFT]) * PROD_W'(DAY_RECIP);
        end
        if (i_cmd.day_rem) begin
            r_days <= days_q;
            r_rem  <= SOD_W'(r_ts - TS_W'(days_q) * TS_W'(SECS_PER_DAY));
        end
        if (i_cmd.tod_h) begin
            r_prod <= PROD_W'(r_rem) * PROD_W'(HOUR_RECIP);
        end
        if (i_cmd.tod_hs) begin
            r_hours   <= hours_q;
            r_tod_rem <= TOD_W'(r_rem - SOD_W'(hours_q) * SOD_W'(SECS_PER_HOUR));
        end
        if (i_cmd.tod_m) begin
            r_prod <= PROD_W'(r_tod_rem) * PROD_W'(MIN_RECIP);
        end
        if (i_cmd.tod_ms) begin
            r_minutes <= min_q;
            r_seconds <= SEC_W'(r_tod_rem - TOD_W'(min_q) * TOD_W'(SECS_PER_MIN));
        end
        if (i_cmd.year_step) begin
            r_days   <= r_days - DAYS_W'(ylen);
            r_year   <= r_year + 1'b1;
            r_mod4   <= r_mod4 + 1'b1;
            r_mod100 <= (r_mod100 == 7'd99) ? 7'd0 : r_mod100 + 1'b1;
            r_mod400 <= (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 1'b1;
        end
        if (i_cmd.month_step) begin
            r_days <= r_days - DAYS_W'(mlen);
            r_midx <= r_midx + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.year         <= r_year;
            r_out.month        <= r_midx + 1'b1;
            r_out.day_of_month <= DAY_W'(r_days) + 1'b1;
            r_out.hours        <= r_hours;
            r_out.minutes      <= r_minutes;
            r_out.seconds      <= r_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: design/unix_seconds_to_calendar.sv
// Unix seconds to calendar date: one input word (seconds since 1970-01-01 UTC) gives
// one result word with year, month, day of month, hours, minutes and seconds. Items are
// handled one at a time. The day split and the time-of-day split are reciprocal
// multiplications; then the block walks the whole years (0 to 68), one year per cycle,
// and the whole months (0 to 11) before the result register is loaded. The next input
// is accepted in the cycle after the result is loaded, and a finished word waits in the
// output register while that input is handled; a result still stalled when the next one
// is ready holds the block until it is taken.
// Depends on ustc_pkg, ustc_if, ustc_ctrl and ustc_dp.
module unix_seconds_to_calendar (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ustc_in_if.sink    i_in,
    ustc_out_if.source o_out
);
    import ustc_pkg::*;

    t_ctl_cmd    cmd;
    t_ctl_status status;

    ustc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ustc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_unix_seconds (i_in.data.unix_seconds),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_word     (o_out.data)
    );

endmodule

FILE: design/ustc_checker.sv
// Port-level checks for unix_seconds_to_calendar, attached by bind.
// Depends on ustc_pkg for the result word type.
module ustc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input ustc_pkg::t_out_word i_out_word
);
    import ustc_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Words accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_word_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_word))
        else $error("result word changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pending != 2'd0) && (r_pending != 2'd3))
        else $error("result word without a matching input word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input accepted again before the previous word finished");

    a_fields_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_word.month != 4'd0) && (i_out_word.month <= 4'd12)
                        && (i_out_word.day_of_month != 5'd0)
                        && (i_out_word.hours <= 5'd23) && (i_out_word.minutes <= 6'd59)
                        && (i_out_word.seconds <= 6'd59))
        else $error("result field out of range");

endmodule

bind unix_seconds_to_calendar ustc_checker u_ustc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.data)
);

FILE: verif/tb_unix_seconds_to_calendar.sv
// Self-checking testbench for unix_seconds_to_calendar: drives timestamp words and checks
// each calendar result against a predictor built into this file.
// Depends on ustc_pkg and ustc_if, and on the block itself.
module tb_unix_seconds_to_calendar;
    timeunit 1ns;
    timeprecision 1ps;
    import ustc_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int PAUSE_MARK   = 450;   // second point where the sender drains the block
    localparam int SEND_QUIET_0 = 600;   // sender never idles for these items
    localparam int SEND_QUIET_1 = 760;
    localparam int RECV_QUIET_0 = 150;   // receiver never stalls for these results
    localparam int RECV_QUIET_1 = 320;
    localparam int IDLE_PCT     = 11;
    localparam int DRAIN_CYCLES = 150;
    localparam int STALL_LIMIT  = 3000;
    localparam int MAX_REPORTS  = 100;
    localparam int unsigned SECS_IN_DAY = 86400;
    localparam int unsigned LAST_DAY    = 24855;  // last day that starts below 2**31 seconds

    logic clk;
    logic rst_n;

    ustc_in_if  in_if ();
    ustc_out_if out_if ();

    unix_seconds_to_calendar u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [TS_W-1:0] pending_stamps[$];
    t_out_word       expected_dates[$];
    int              sent_cnt;
    int              result_cnt;
    int              directed_count;
    int              err_count;
    int              stall_cycles;
    int              sent_next;
    int              got_next;
    bit              holding_off;
    bit              idle_now;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_leap_year(input int unsigned yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    endfunction

    // Date and time of day for one timestamp: peel off whole years, then whole months.
    function automatic t_out_word calendar_of(input logic [TS_W-1:0] stamp);
        int unsigned      day_count;
        int unsigned      sec_of_day;
        int unsigned      yr;
        int unsigned      mlen;
        logic [MONTH_W-1:0] mon;
        bit               leap;
        t_out_word        w;
        day_count  = stamp / SECS_IN_DAY;
        sec_of_day = stamp % SECS_IN_DAY;
        yr         = 1970;
        while (day_count >= (is_leap_year(yr) ? 366 : 365)) begin
            day_count -= is_leap_year(yr) ? 366 : 365;
            yr++;
        end
        leap = is_leap_year(yr);
        mon  = MON_JAN;
        // December takes whatever is left.
        while (mon != MON_DEC) begin
            case (mon)
                MON_FEB: mlen = leap ? 29 : 28;
                MON_APR, MON_JUN, MON_SEP, MON_NOV: mlen = 30;
                default: mlen = 31;
            endcase
            if (day_count < mlen) break;
            day_count -= mlen;
            mon++;
        end
        w.year         = YEAR_W'(yr);
        w.month        = mon + 1'b1;
        w.day_of_month = DAY_W'(day_count + 1);
        w.hours        = HOURS_W'(sec_of_day / 3600);
        w.minutes      = MIN_W'((sec_of_day % 3600) / 60);
        w.seconds      = SEC_W'(sec_of_day % 60);
        return w;
    endfunction

    // Sender: offers the queued timestamps and records the date each accepted word must give.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            sent_next = sent_cnt + ((in_if.valid && in_if.ready) ? 1 : 0);
            got_next  = result_cnt + ((out_if.valid && out_if.ready) ? 1 : 0);
            if (in_if.valid && in_if.ready) begin
                expected_dates.push_back(calendar_of(in_if.data.unix_seconds));
            end
            sent_cnt <= sent_next;
            if (!in_if.valid || in_if.ready) begin
                holding_off = (sent_next == directed_count || sent_next == PAUSE_MARK)
                              && sent_next != got_next;
                idle_now = !(sent_next >= SEND_QUIET_0 && sent_next < SEND_QUIET_1)
                           && $urandom_range(0, 99) < IDLE_PCT;
                if (pending_stamps.size() != 0 && !holding_off && !idle_now) begin
                    in_if.valid             <= 1'b1;
                    in_if.data.unix_seconds <= pending_stamps.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, result check and the no-progress watchdog.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= (result_cnt >= RECV_QUIET_0 && result_cnt < RECV_QUIET_1)
                            || $urandom_range(0, 99) >= IDLE_PCT;
            if (out_if.valid && out_if.ready) begin
                result_cnt <= result_cnt + 1;
                if (expected_dates.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected word, expected none, got %0d-%0d-%0d %0d:%0d:%0d",
                                 $time, out_if.data.year, out_if.data.month,
                                 out_if.data.day_of_month, out_if.data.hours,
                                 out_if.data.minutes, out_if.data.seconds);
                end else begin
                    t_out_word want;
                    want = expected_dates.pop_front();
                    if (out_if.data.year !== want.year || out_if.data.month !== want.month ||
                        out_if.data.day_of_month !== want.day_of_month ||
                        out_if.data.hours !== want.hours ||
                        out_if.data.minutes !== want.minutes ||
                        out_if.data.seconds !== want.seconds) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                                     $time, want.year, want.month, want.day_of_month,
                                     want.hours, want.minutes, want.seconds,
                                     out_if.data.year, out_if.data.month,
                                     out_if.data.day_of_month, out_if.data.hours,
                                     out_if.data.minutes, out_if.data.seconds);
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned pick;
        int unsigned day;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        out_if.ready   = 1'b0;
        sent_cnt       = 0;
        result_cnt     = 0;
        err_count      = 0;
        stall_cycles   = 0;

        // Field extremes, time-of-day rollovers, year and month ends, leap days.
        pending_stamps = '{
            31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
            31'd31449600,     // last day of 1970
            31'd31535999,     // last second of 1970
            31'd31536000,     // first second of 1971
            31'd36633599,     // end of February in a common year
            31'd68169600,     // leap day 1972
            31'd68256000,     // the day after a leap day
            31'd94694399,     // last second of a leap year
            31'd951782400,    // leap day of a century year divisible by 400
            31'd978307199,    // last second of 2000
            31'd2145916799,   // last second of 2037
            31'd2147472000,   // start of the last day in range
            31'd2147483646,
            31'd2147483647,   // largest timestamp
            31'd1073741824,
            31'd1431655765,
            31'd715827882
        };
        directed_count = pending_stamps.size();

        // Mostly uniform stamps, plus a share placed on day boundaries and in the early years.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                pending_stamps.push_back(TS_W'($urandom));
            end else if (pick < 85) begin
                day = $urandom_range(1, LAST_DAY);
                pending_stamps.push_back(TS_W'(day * SECS_IN_DAY + $urandom_range(0, 2) - 1));
            end else begin
                pending_stamps.push_back(TS_W'($urandom_range(0, SECS_IN_DAY * 1500)));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_stamps.size() != 0 || in_if.valid || expected_dates.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
